FILE: sv/cbfd_pkg.sv
// ----------------------------------------------------------------------------
// cbfd_pkg
// Shared types, codes and constants of the cubic Bezier flattener.
// ----------------------------------------------------------------------------
package cbfd_pkg;

  localparam int CW                  = 24;
  localparam int ACC_W               = 64;
  localparam int STEP_W              = 11;
  localparam int LEFT_W              = 12;
  localparam int N3_W                = 34;
  localparam int SCALE_W             = 16;
  localparam int LEN_W               = 27;
  localparam int SQ_W                = 50;
  localparam int ROOT_ITER           = 25;
  localparam int DIV_W               = 60;
  localparam int HW_STEP_CAP         = 2047;
  localparam int MIN_STEPS           = 4;
  localparam int MAX_STEPS_DEF       = 1024;
  localparam int COORD_FRAC_BITS_DEF = 8;

  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd256;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_REWIND = 2'd1;
  localparam logic [1:0] ACT_FETCH  = 2'd2;

  localparam logic [1:0] CMD_STOP = 2'd0;
  localparam logic [1:0] CMD_MOVE = 2'd1;
  localparam logic [1:0] CMD_LINE = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_REWIND = 2'd1,
    OP_FETCH  = 2'd2
  } op_t;

  typedef logic [3:0][1:0][CW-1:0] pts_t;

  typedef struct packed {
    op_t  op;
    pts_t pt;
  } item_t;

endpackage

FILE: sv/cbfd_if.sv
// ----------------------------------------------------------------------------
// cbfd channel interfaces
// Input, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbfd_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic signed [cbfd_pkg::CW-1:0] p0_x;
  logic signed [cbfd_pkg::CW-1:0] p0_y;
  logic signed [cbfd_pkg::CW-1:0] p1_x;
  logic signed [cbfd_pkg::CW-1:0] p1_y;
  logic signed [cbfd_pkg::CW-1:0] p2_x;
  logic signed [cbfd_pkg::CW-1:0] p2_y;
  logic signed [cbfd_pkg::CW-1:0] p3_x;
  logic signed [cbfd_pkg::CW-1:0] p3_y;
  modport source (output valid, action, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                  input ready);
  modport sink (input valid, action, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                output ready);
endinterface

interface cbfd_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic signed [cbfd_pkg::CW-1:0] out_x;
  logic signed [cbfd_pkg::CW-1:0] out_y;
  modport source (output valid, command, out_x, out_y, input ready);
  modport sink (input valid, command, out_x, out_y, output ready);
endinterface

interface cbfd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cbfd_pkg::SCALE_W-1:0]      approx_scale;
  modport source (output valid, approx_scale, input ready);
  modport sink (input valid, approx_scale, output ready);
endinterface

FILE: sv/cubic_bezier_forward_difference.sv
// Stop, move-to and end-point fetches are answered from stored state; interior
//   fetches run two 60-step restoring divisions by 2*N^3 for rounding.
// Load runs three 25-step square roots and six shift-add multiplies per axis;
//   rewind runs the start-point multiplies only. One item is worked at a time;
//   a 2-deep input queue and an output register decouple both channels.
// Reset: scale returns to 1.0, curve state clears, walk stopped; no clearing pass.
// ----------------------------------------------------------------------------
// cubic_bezier_forward_difference
// Cubic Bezier flattener by forward differencing, top level.
// ----------------------------------------------------------------------------
module cubic_bezier_forward_difference #(
  parameter int MAX_STEPS       = cbfd_pkg::MAX_STEPS_DEF,
  parameter int COORD_FRAC_BITS = cbfd_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cbfd_in_if.sink    in_ch,
  cbfd_out_if.source out_ch,
  cbfd_cfg_if.sink   cfg_ch
);

  logic [cbfd_pkg::SCALE_W-1:0] scale_r, scale_nxt;
  logic                         q_valid, q_pop;
  cbfd_pkg::item_t              q_item;

  assign cfg_ch.ready = 1'b1;
  assign scale_nxt    = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.approx_scale : scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= cbfd_pkg::SCALE_RST;
    end else begin
      scale_r <= scale_nxt;
    end
  end

  cbfd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  cbfd_back #(
    .MAX_STEPS       (MAX_STEPS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .approx_scale (scale_r),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_item       (q_item),
    .out_ch       (out_ch)
  );

endmodule

FILE: sv/cbfd_front.sv
// ----------------------------------------------------------------------------
// cbfd_front
// Accepts input transfers, drops unknown actions, queues the rest (2 deep).
// ----------------------------------------------------------------------------
module cbfd_front (
  input  logic            clk,
  input  logic            rst_n,
  cbfd_in_if.sink         in_ch,
  input  logic            q_pop,
  output logic            q_valid,
  output cbfd_pkg::item_t q_item
);

  cbfd_pkg::item_t ent_r [2];
  cbfd_pkg::item_t new_item;
  logic            wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            known, push;

  always_comb begin
    known       = 1'b1;
    new_item.op = cbfd_pkg::OP_FETCH;
    case (in_ch.action)
      cbfd_pkg::ACT_LOAD:   new_item.op = cbfd_pkg::OP_LOAD;
      cbfd_pkg::ACT_REWIND: new_item.op = cbfd_pkg::OP_REWIND;
      cbfd_pkg::ACT_FETCH:  new_item.op = cbfd_pkg::OP_FETCH;
      default:              known = 1'b0;
    endcase
    new_item.pt[0][0] = in_ch.p0_x;
    new_item.pt[0][1] = in_ch.p0_y;
    new_item.pt[1][0] = in_ch.p1_x;
    new_item.pt[1][1] = in_ch.p1_y;
    new_item.pt[2][0] = in_ch.p2_x;
    new_item.pt[2][1] = in_ch.p2_y;
    new_item.pt[3][0] = in_ch.p3_x;
    new_item.pt[3][1] = in_ch.p3_y;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready && known;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = ent_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= new_item;
    end
  end

endmodule

FILE: sv/cbfd_back.sv
// ----------------------------------------------------------------------------
// cbfd_back
// Executes queued items: step count, difference setup, walk and rounding.
// ----------------------------------------------------------------------------
module cbfd_back #(
  parameter int MAX_STEPS       = cbfd_pkg::MAX_STEPS_DEF,
  parameter int COORD_FRAC_BITS = cbfd_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [cbfd_pkg::SCALE_W-1:0] approx_scale,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  cbfd_pkg::item_t              q_item,
  cbfd_out_if.source                   out_ch
);

  localparam int AW       = cbfd_pkg::ACC_W;
  localparam int SH       = COORD_FRAC_BITS + 10;
  localparam int STEP_CAP = (MAX_STEPS > cbfd_pkg::HW_STEP_CAP) ?
                            cbfd_pkg::HW_STEP_CAP : MAX_STEPS;
  localparam int PROD_W   = cbfd_pkg::LEN_W + cbfd_pkg::SCALE_W;
  localparam int NRAW_W   = PROD_W + 1;
  localparam logic [NRAW_W-1:0] RND_C = NRAW_W'(1) << (SH - 1);
  localparam logic [cbfd_pkg::SQ_W-1:0] ROOT_TOP =
    cbfd_pkg::SQ_W'(1) << (2 * (cbfd_pkg::ROOT_ITER - 1));

  localparam logic [2:0] J_C1   = 3'd0;
  localparam logic [2:0] J_C1N  = 3'd1;
  localparam logic [2:0] J_C2   = 3'd2;
  localparam logic [2:0] J_P0   = 3'd3;
  localparam logic [2:0] J_P0N  = 3'd4;
  localparam logic [2:0] J_P0NN = 3'd5;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_SQX   = 10'b0000000010,
    ST_SQY   = 10'b0000000100,
    ST_ROOT  = 10'b0000001000,
    ST_SCALE = 10'b0000010000,
    ST_CUBE  = 10'b0000100000,
    ST_MUL   = 10'b0001000000,
    ST_DSET  = 10'b0010000000,
    ST_DIV   = 10'b0100000000,
    ST_EMIT  = 10'b1000000000
  } state_t;

  state_t st_r, st_nxt;

  // architectural state
  logic signed [cbfd_pkg::CW-1:0] sp_r [2], sp_nxt [2], ep_r [2], ep_nxt [2];
  logic signed [AW-1:0] acc_r [2], acc_nxt [2], d1_r [2], d1_nxt [2];
  logic signed [AW-1:0] d2_r [2], d2_nxt [2], d3_r [2], d3_nxt [2];
  logic signed [AW-1:0] sd1_r [2], sd1_nxt [2], sd2_r [2], sd2_nxt [2];
  logic [cbfd_pkg::STEP_W-1:0] tot_r, tot_nxt;
  logic [cbfd_pkg::N3_W-1:0]   n3_r, n3_nxt;
  logic signed [cbfd_pkg::LEFT_W-1:0] left_r, left_nxt;

  // working registers
  cbfd_pkg::item_t cur_r, cur_nxt;
  cbfd_pkg::pts_t  lp_r, lp_nxt;
  logic [1:0]      seg_r, seg_nxt;
  logic [cbfd_pkg::SQ_W-1:0] sq_r, sq_nxt, rv_r, rv_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [4:0]      rc_r, rc_nxt;
  logic [cbfd_pkg::LEN_W-1:0] len_r, len_nxt;
  logic            cb_r, cb_nxt;
  logic            ax_r, ax_nxt, rw_r, rw_nxt;
  logic [2:0]      jb_r, jb_nxt;
  logic [3:0]      mb_r, mb_nxt;
  logic signed [AW-1:0] mx_r, mx_nxt, macc_r, macc_nxt;
  logic            dax_r, dax_nxt, neg_r, neg_nxt;
  logic [cbfd_pkg::DIV_W-1:0] dq_r, dq_nxt;
  logic [cbfd_pkg::N3_W:0]    rem_r, rem_nxt;
  logic [5:0]      dc_r, dc_nxt;
  logic [1:0]      cmd_r, cmd_nxt;
  logic signed [cbfd_pkg::CW-1:0] ox_r, ox_nxt, oy_r, oy_nxt;

  // output register
  logic            ov_r, ov_nxt;
  logic [1:0]      ocmd_r, ocmd_nxt;
  logic signed [cbfd_pkg::CW-1:0] oox_r, oox_nxt, ooy_r, ooy_nxt;

  // combinational helpers
  logic signed [AW-1:0] pe [4][2];
  logic signed [AW-1:0] c1 [2], c2 [2], c3 [2];
  logic signed [AW-1:0] k3c1 [2], k3c2 [2], k6c2 [2], k6c3 [2];
  logic signed [cbfd_pkg::CW:0]     dxs, dys;
  logic signed [2*cbfd_pkg::CW+1:0] dsqx, dsqy;
  logic [cbfd_pkg::SQ_W-1:0] rtrial, res_new;
  logic [PROD_W-1:0]  prod_s;
  logic [NRAW_W-1:0]  nraw;
  logic signed [AW-1:0] mac_sum, nn, dd64, uu;
  logic [cbfd_pkg::N3_W:0]   dd;
  logic [cbfd_pkg::N3_W+1:0] dtrial;
  logic            dge;
  logic [cbfd_pkg::DIV_W-1:0] qv;
  logic signed [cbfd_pkg::CW-1:0] satv;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int a = 0; a < 2; a++) begin
        pe[i][a] = AW'($signed(cur_r.pt[i][a]));
      end
    end
    for (int a = 0; a < 2; a++) begin
      c1[a]   = pe[1][a] - pe[0][a];
      c2[a]   = pe[0][a] - (pe[1][a] <<< 1) + pe[2][a];
      c3[a]   = 64'sd3 * (pe[1][a] - pe[2][a]) - pe[0][a] + pe[3][a];
      k3c1[a] = 64'sd3 * c1[a];
      k3c2[a] = 64'sd3 * c2[a];
      k6c2[a] = 64'sd6 * c2[a];
      k6c3[a] = 64'sd6 * c3[a];
    end
  end

  assign dxs  = $signed({lp_r[1][0][cbfd_pkg::CW-1], lp_r[1][0]})
              - $signed({lp_r[0][0][cbfd_pkg::CW-1], lp_r[0][0]});
  assign dys  = $signed({lp_r[1][1][cbfd_pkg::CW-1], lp_r[1][1]})
              - $signed({lp_r[0][1][cbfd_pkg::CW-1], lp_r[0][1]});
  assign dsqx = dxs * dxs;
  assign dsqy = dys * dys;

  assign rtrial  = res_r + bit_r;
  assign res_new = (rv_r >= rtrial) ? ((res_r >> 1) + bit_r) : (res_r >> 1);

  assign prod_s = PROD_W'(len_r) * PROD_W'(approx_scale);
  assign nraw   = (NRAW_W'(prod_s) + RND_C) >> SH;

  assign mac_sum = macc_r + (tot_r[mb_r] ? mx_r : '0);

  assign dd     = {n3_r, 1'b0};
  assign dd64   = AW'(dd);
  assign nn     = (acc_r[dax_r] <<< 1) + AW'(n3_r);
  assign uu     = nn[AW-1] ? (dd64 - nn - 64'sd1) : nn;
  assign dtrial = {rem_r, dq_r[cbfd_pkg::DIV_W-1]};
  assign dge    = (dtrial >= {1'b0, dd});
  assign qv     = {dq_r[cbfd_pkg::DIV_W-2:0], dge};

  always_comb begin
    if (!neg_r) begin
      satv = (qv > cbfd_pkg::DIV_W'(24'h7FFFFF)) ? 24'sh7FFFFF : $signed(qv[23:0]);
    end else begin
      satv = (qv > cbfd_pkg::DIV_W'(24'h800000)) ? 24'sh800000 : $signed(-qv[23:0]);
    end
  end

  always_comb begin
    st_nxt = st_r;
    sp_nxt = sp_r;   ep_nxt = ep_r;
    acc_nxt = acc_r; d1_nxt = d1_r; d2_nxt = d2_r; d3_nxt = d3_r;
    sd1_nxt = sd1_r; sd2_nxt = sd2_r;
    tot_nxt = tot_r; n3_nxt = n3_r; left_nxt = left_r;
    cur_nxt = cur_r; lp_nxt = lp_r; seg_nxt = seg_r;
    sq_nxt = sq_r; rv_nxt = rv_r; res_nxt = res_r; bit_nxt = bit_r; rc_nxt = rc_r;
    len_nxt = len_r; cb_nxt = cb_r;
    ax_nxt = ax_r; rw_nxt = rw_r; jb_nxt = jb_r; mb_nxt = mb_r;
    mx_nxt = mx_r; macc_nxt = macc_r;
    dax_nxt = dax_r; neg_nxt = neg_r; dq_nxt = dq_r; rem_nxt = rem_r; dc_nxt = dc_r;
    cmd_nxt = cmd_r; ox_nxt = ox_r; oy_nxt = oy_r;
    ov_nxt = ov_r; ocmd_nxt = ocmd_r; oox_nxt = oox_r; ooy_nxt = ooy_r;
    q_pop = 1'b0;

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.op)
            cbfd_pkg::OP_LOAD: begin
              cur_nxt = q_item;
              lp_nxt  = q_item.pt;
              for (int a = 0; a < 2; a++) begin
                sp_nxt[a] = q_item.pt[0][a];
                ep_nxt[a] = q_item.pt[3][a];
              end
              seg_nxt = 2'd0;
              len_nxt = '0;
              st_nxt  = ST_SQX;
            end
            cbfd_pkg::OP_REWIND: begin
              if (tot_r == '0) begin
                left_nxt = -12'sd1;
              end else begin
                d1_nxt   = sd1_r;
                d2_nxt   = sd2_r;
                rw_nxt   = 1'b1;
                ax_nxt   = 1'b0;
                jb_nxt   = J_P0;
                mx_nxt   = AW'(sp_r[0]);
                macc_nxt = '0;
                mb_nxt   = '0;
                st_nxt   = ST_MUL;
              end
            end
            cbfd_pkg::OP_FETCH: begin
              if (left_r < 0) begin
                cmd_nxt = cbfd_pkg::CMD_STOP;
                ox_nxt  = '0;
                oy_nxt  = '0;
                st_nxt  = ST_EMIT;
              end else if (left_r == $signed({1'b0, tot_r})) begin
                cmd_nxt  = cbfd_pkg::CMD_MOVE;
                ox_nxt   = sp_r[0];
                oy_nxt   = sp_r[1];
                left_nxt = left_r - 12'sd1;
                st_nxt   = ST_EMIT;
              end else if (left_r == 12'sd0) begin
                cmd_nxt  = cbfd_pkg::CMD_LINE;
                ox_nxt   = ep_r[0];
                oy_nxt   = ep_r[1];
                left_nxt = left_r - 12'sd1;
                st_nxt   = ST_EMIT;
              end else begin
                for (int a = 0; a < 2; a++) begin
                  acc_nxt[a] = acc_r[a] + d1_r[a];
                  d1_nxt[a]  = d1_r[a] + d2_r[a];
                  d2_nxt[a]  = d2_r[a] + d3_r[a];
                end
                left_nxt = left_r - 12'sd1;
                dax_nxt  = 1'b0;
                st_nxt   = ST_DSET;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SQX: begin
        sq_nxt = $unsigned(dsqx);
        st_nxt = ST_SQY;
      end

      ST_SQY: begin
        rv_nxt  = sq_r + $unsigned(dsqy);
        res_nxt = '0;
        bit_nxt = ROOT_TOP;
        rc_nxt  = '0;
        st_nxt  = ST_ROOT;
      end

      ST_ROOT: begin
        if (rv_r >= rtrial) begin
          rv_nxt = rv_r - rtrial;
        end
        res_nxt = res_new;
        bit_nxt = bit_r >> 2;
        rc_nxt  = rc_r + 5'd1;
        if (rc_r == 5'(cbfd_pkg::ROOT_ITER - 1)) begin
          len_nxt = len_r + cbfd_pkg::LEN_W'(res_new[cbfd_pkg::ROOT_ITER-1:0]);
          if (seg_r == 2'd2) begin
            st_nxt = ST_SCALE;
          end else begin
            seg_nxt = seg_r + 2'd1;
            lp_nxt  = {lp_r[3], lp_r[3], lp_r[2], lp_r[1]};
            st_nxt  = ST_SQX;
          end
        end
      end

      ST_SCALE: begin
        if (nraw < NRAW_W'(cbfd_pkg::MIN_STEPS)) begin
          tot_nxt = cbfd_pkg::STEP_W'(cbfd_pkg::MIN_STEPS);
        end else if (nraw > NRAW_W'(STEP_CAP)) begin
          tot_nxt = cbfd_pkg::STEP_W'(STEP_CAP);
        end else begin
          tot_nxt = nraw[cbfd_pkg::STEP_W-1:0];
        end
        cb_nxt = 1'b0;
        st_nxt = ST_CUBE;
      end

      ST_CUBE: begin
        if (!cb_r) begin
          n3_nxt = cbfd_pkg::N3_W'(tot_r) * cbfd_pkg::N3_W'(tot_r);
          cb_nxt = 1'b1;
        end else begin
          n3_nxt   = cbfd_pkg::N3_W'(n3_r[2*cbfd_pkg::STEP_W-1:0]) * cbfd_pkg::N3_W'(tot_r);
          rw_nxt   = 1'b0;
          ax_nxt   = 1'b0;
          jb_nxt   = J_C1;
          mx_nxt   = k3c1[0];
          macc_nxt = '0;
          mb_nxt   = '0;
          st_nxt   = ST_MUL;
        end
      end

      ST_MUL: begin
        macc_nxt = mac_sum;
        mx_nxt   = mx_r <<< 1;
        mb_nxt   = mb_r + 4'd1;
        if (mb_r == 4'(cbfd_pkg::STEP_W - 1)) begin
          macc_nxt = '0;
          mb_nxt   = '0;
          case (jb_r)
            J_C1: begin
              jb_nxt = J_C1N;
              mx_nxt = mac_sum + k3c2[ax_r];
            end
            J_C1N: begin
              d1_nxt[ax_r]  = mac_sum + c3[ax_r];
              sd1_nxt[ax_r] = mac_sum + c3[ax_r];
              jb_nxt        = J_C2;
              mx_nxt        = k6c2[ax_r];
            end
            J_C2: begin
              d2_nxt[ax_r]  = mac_sum + k6c3[ax_r];
              sd2_nxt[ax_r] = mac_sum + k6c3[ax_r];
              d3_nxt[ax_r]  = k6c3[ax_r];
              jb_nxt        = J_P0;
              mx_nxt        = AW'(sp_r[ax_r]);
            end
            J_P0: begin
              jb_nxt = J_P0N;
              mx_nxt = mac_sum;
            end
            J_P0N: begin
              jb_nxt = J_P0NN;
              mx_nxt = mac_sum;
            end
            J_P0NN: begin
              acc_nxt[ax_r] = mac_sum;
              if (!ax_r) begin
                ax_nxt = 1'b1;
                jb_nxt = rw_r ? J_P0 : J_C1;
                mx_nxt = rw_r ? AW'(sp_r[1]) : k3c1[1];
              end else begin
                left_nxt = $signed({1'b0, tot_r});
                st_nxt   = ST_IDLE;
              end
            end
            default: st_nxt = ST_IDLE;
          endcase
        end
      end

      ST_DSET: begin
        neg_nxt = nn[AW-1];
        dq_nxt  = uu[cbfd_pkg::DIV_W-1:0];
        rem_nxt = '0;
        dc_nxt  = '0;
        st_nxt  = ST_DIV;
      end

      ST_DIV: begin
        rem_nxt = dge ? (dtrial[cbfd_pkg::N3_W:0] - dd) : dtrial[cbfd_pkg::N3_W:0];
        dq_nxt  = qv;
        dc_nxt  = dc_r + 6'd1;
        if (dc_r == 6'(cbfd_pkg::DIV_W - 1)) begin
          if (!dax_r) begin
            ox_nxt  = satv;
            dax_nxt = 1'b1;
            st_nxt  = ST_DSET;
          end else begin
            oy_nxt  = satv;
            cmd_nxt = cbfd_pkg::CMD_LINE;
            st_nxt  = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt   = 1'b1;
          ocmd_nxt = cmd_r;
          oox_nxt  = ox_r;
          ooy_nxt  = oy_r;
          st_nxt   = ST_IDLE;
        end
      end

      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_ch.valid   = ov_r;
  assign out_ch.command = ocmd_r;
  assign out_ch.out_x   = oox_r;
  assign out_ch.out_y   = ooy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      ov_r   <= 1'b0;
      tot_r  <= '0;
      n3_r   <= '0;
      left_r <= -12'sd1;
      for (int a = 0; a < 2; a++) begin
        sp_r[a]  <= '0;
        ep_r[a]  <= '0;
        acc_r[a] <= '0;
        d1_r[a]  <= '0;
        d2_r[a]  <= '0;
        d3_r[a]  <= '0;
        sd1_r[a] <= '0;
        sd2_r[a] <= '0;
      end
    end else begin
      st_r   <= st_nxt;
      ov_r   <= ov_nxt;
      tot_r  <= tot_nxt;
      n3_r   <= n3_nxt;
      left_r <= left_nxt;
      sp_r   <= sp_nxt;
      ep_r   <= ep_nxt;
      acc_r  <= acc_nxt;
      d1_r   <= d1_nxt;
      d2_r   <= d2_nxt;
      d3_r   <= d3_nxt;
      sd1_r  <= sd1_nxt;
      sd2_r  <= sd2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    lp_r   <= lp_nxt;
    seg_r  <= seg_nxt;
    sq_r   <= sq_nxt;
    rv_r   <= rv_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
    rc_r   <= rc_nxt;
    len_r  <= len_nxt;
    cb_r   <= cb_nxt;
    ax_r   <= ax_nxt;
    rw_r   <= rw_nxt;
    jb_r   <= jb_nxt;
    mb_r   <= mb_nxt;
    mx_r   <= mx_nxt;
    macc_r <= macc_nxt;
    dax_r  <= dax_nxt;
    neg_r  <= neg_nxt;
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    dc_r   <= dc_nxt;
    cmd_r  <= cmd_nxt;
    ox_r   <= ox_nxt;
    oy_r   <= oy_nxt;
    ocmd_r <= ocmd_nxt;
    oox_r  <= oox_nxt;
    ooy_r  <= ooy_nxt;
  end

  a_steps_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE && tot_r != '0) |->
      (tot_r >= cbfd_pkg::STEP_W'(cbfd_pkg::MIN_STEPS) &&
       tot_r <= cbfd_pkg::STEP_W'(STEP_CAP)))
    else $error("step count out of range");

  a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE && left_r >= 0) |-> (left_r[cbfd_pkg::STEP_W-1:0] <= tot_r))
    else $error("walk counter beyond step count");

  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ocmd_r == cbfd_pkg::CMD_STOP) |-> (oox_r == '0 && ooy_r == '0))
    else $error("stop vertex not zero");

endmodule

FILE: tb/cubic_bezier_forward_difference_test.sv
// ----------------------------------------------------------------------------
// cubic_bezier_forward_difference_test
// Drives loads, rewinds and vertex fetches into the flattener, predicts every
// vertex with a forward-differencing model of its own and checks each result
// transfer in order, across scale settings and idle/stall phases.
// ----------------------------------------------------------------------------
module cubic_bezier_forward_difference_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 250;
  localparam int FETCH_CAP   = 30;

  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  typedef struct {
    logic [1:0]                      action;
    logic signed [cbfd_pkg::CW-1:0]  pt [8];
  } curve_item_t;

  typedef struct {
    logic [1:0]              command;
    logic [cbfd_pkg::CW-1:0] x;
    logic [cbfd_pkg::CW-1:0] y;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cbfd_in_if  in_ch ();
  cbfd_out_if out_ch ();
  cbfd_cfg_if cfg_ch ();

  cubic_bezier_forward_difference dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Flattener state as predicted
  int unsigned  scale_q88;
  longint       start_pt [2], end_pt [2];
  longint       walk_pos [2], d1 [2], d2 [2], d3 [2], d1_init [2], d2_init [2];
  int           seg_count;
  int           segs_left;

  vertex_t vertex_q [$];
  int      errors;
  int      cycles;
  int      sent;
  int      send_idle_pct;
  int      recv_stall_pct;
  logic    hold_off;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits >>= 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v -= res + bits;
        res = (res >> 1) + bits;
      end else begin
        res >>= 1;
      end
      bits >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned polygon_edge(longint ax, longint ay, longint bx,
                                                   longint by);
    longint dx, dy;
    dx = bx - ax;
    dy = by - ay;
    return int_sqrt(longint'(dx * dx) + longint'(dy * dy));
  endfunction

  function automatic logic [cbfd_pkg::CW-1:0] round_sat(longint p, longint d);
    longint n, dd, q;
    n = 2 * p + d;
    dd = 2 * d;
    q = n / dd;
    if (n % dd < 0) q -= 1;
    if (q > 8388607) q = 8388607;
    if (q < -8388608) q = -8388608;
    return q[cbfd_pkg::CW-1:0];
  endfunction

  task automatic flattener_reset();
    scale_q88 = cbfd_pkg::SCALE_RST;
    for (int a = 0; a < 2; a++) begin
      start_pt[a] = 0; end_pt[a] = 0; walk_pos[a] = 0;
      d1[a] = 0; d2[a] = 0; d3[a] = 0; d1_init[a] = 0; d2_init[a] = 0;
    end
    seg_count = 0;
    segs_left = -1;
  endtask

  task automatic predict_vertex(curve_item_t it);
    longint p [4][2];
    longint unsigned len, n;
    longint nn, n2, n3, c1, c2, c3;
    vertex_t v;
    if (it.action == cbfd_pkg::ACT_LOAD) begin
      for (int i = 0; i < 4; i++) begin
        p[i][0] = it.pt[2*i];
        p[i][1] = it.pt[2*i+1];
      end
      len = polygon_edge(p[0][0], p[0][1], p[1][0], p[1][1])
          + polygon_edge(p[1][0], p[1][1], p[2][0], p[2][1])
          + polygon_edge(p[2][0], p[2][1], p[3][0], p[3][1]);
      n = (len * scale_q88 + (64'd1 << (cbfd_pkg::COORD_FRAC_BITS_DEF + 9)))
          >> (cbfd_pkg::COORD_FRAC_BITS_DEF + 10);
      if (n < cbfd_pkg::MIN_STEPS) n = cbfd_pkg::MIN_STEPS;
      if (n > cbfd_pkg::MAX_STEPS_DEF) n = cbfd_pkg::MAX_STEPS_DEF;
      seg_count = int'(n);
      nn = longint'(n);
      n2 = nn * nn;
      n3 = n2 * nn;
      for (int a = 0; a < 2; a++) begin
        c1 = p[1][a] - p[0][a];
        c2 = p[0][a] - 2 * p[1][a] + p[2][a];
        c3 = 3 * (p[1][a] - p[2][a]) - p[0][a] + p[3][a];
        start_pt[a] = p[0][a];
        end_pt[a] = p[3][a];
        walk_pos[a] = p[0][a] * n3;
        d1[a] = 3 * c1 * n2 + 3 * c2 * nn + c3;
        d2[a] = 6 * c2 * nn + 6 * c3;
        d3[a] = 6 * c3;
        d1_init[a] = d1[a];
        d2_init[a] = d2[a];
      end
      segs_left = seg_count;
    end else if (it.action == cbfd_pkg::ACT_REWIND) begin
      if (seg_count == 0) begin
        segs_left = -1;
      end else begin
        nn = seg_count;
        segs_left = seg_count;
        for (int a = 0; a < 2; a++) begin
          walk_pos[a] = start_pt[a] * nn * nn * nn;
          d1[a] = d1_init[a];
          d2[a] = d2_init[a];
        end
      end
    end else if (it.action == cbfd_pkg::ACT_FETCH) begin
      if (segs_left < 0) begin
        v = '{cbfd_pkg::CMD_STOP, '0, '0};
      end else if (segs_left == seg_count) begin
        v = '{cbfd_pkg::CMD_MOVE, start_pt[0][cbfd_pkg::CW-1:0],
              start_pt[1][cbfd_pkg::CW-1:0]};
        segs_left--;
      end else if (segs_left == 0) begin
        v = '{cbfd_pkg::CMD_LINE, end_pt[0][cbfd_pkg::CW-1:0],
              end_pt[1][cbfd_pkg::CW-1:0]};
        segs_left--;
      end else begin
        for (int a = 0; a < 2; a++) begin
          walk_pos[a] += d1[a];
          d1[a] += d2[a];
          d2[a] += d3[a];
        end
        nn = seg_count;
        v.command = cbfd_pkg::CMD_LINE;
        v.x = round_sat(walk_pos[0], nn * nn * nn);
        v.y = round_sat(walk_pos[1], nn * nn * nn);
        segs_left--;
      end
      vertex_q.push_back(v);
    end
  endtask

  task automatic send_item(curve_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= it.action;
    in_ch.p0_x <= it.pt[0]; in_ch.p0_y <= it.pt[1];
    in_ch.p1_x <= it.pt[2]; in_ch.p1_y <= it.pt[3];
    in_ch.p2_x <= it.pt[4]; in_ch.p2_y <= it.pt[5];
    in_ch.p3_x <= it.pt[6]; in_ch.p3_y <= it.pt[7];
    do @(posedge clk); while (!in_ch.ready);
    predict_vertex(it);
    sent++;
  endtask

  task automatic send_op(logic [1:0] action);
    curve_item_t it;
    it.action = action;
    foreach (it.pt[i]) it.pt[i] = cbfd_pkg::CW'($urandom);
    send_item(it);
  endtask

  task automatic send_curve(logic signed [cbfd_pkg::CW-1:0] a0, a1, b0, b1, c0, c1, e0,
                            e1);
    curve_item_t it;
    it.action = cbfd_pkg::ACT_LOAD;
    it.pt = '{a0, a1, b0, b1, c0, c1, e0, e1};
    send_item(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_scale(logic [cbfd_pkg::SCALE_W-1:0] value);
    drain();
    cfg_ch.valid        <= 1'b1;
    cfg_ch.approx_scale <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    scale_q88 = value;
  endtask

  always @(posedge clk) begin
    vertex_t v;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (vertex_q.size() == 0) begin
        $display("%0t unexpected vertex cmd %0d x %h y %h", $time, out_ch.command,
                 out_ch.out_x, out_ch.out_y);
        errors++;
      end else begin
        v = vertex_q.pop_front();
        if (out_ch.command !== v.command) begin
          $display("%0t command exp %0d act %0d", $time, v.command, out_ch.command);
          errors++;
        end
        if (out_ch.out_x !== v.x) begin
          $display("%0t out_x exp %h act %h", $time, v.x, out_ch.out_x);
          errors++;
        end
        if (out_ch.out_y !== v.y) begin
          $display("%0t out_y exp %h act %h", $time, v.y, out_ch.out_y);
          errors++;
        end
      end
    end
    out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Well-formed walks around a random origin, with occasional full-range curves,
  // mid-walk rewinds and ignored actions.
  task automatic run_walks(int n_items, int spread);
    logic signed [cbfd_pkg::CW-1:0] q [8];
    int base [2];
    int stop_at, fetches;
    stop_at = sent + n_items;
    while (sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        foreach (q[i]) q[i] = cbfd_pkg::CW'($urandom);
      end else begin
        foreach (base[a]) base[a] = int'($urandom_range(16000000)) - 8000000;
        foreach (q[i]) begin
          q[i] = cbfd_pkg::CW'(base[i % 2] + int'($urandom_range(2 * spread)) - spread);
        end
      end
      send_curve(q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7]);
      fetches = (seg_count + 2 > FETCH_CAP) ? FETCH_CAP : seg_count + 2;
      fetches += $urandom_range(1);
      for (int k = 0; k < fetches; k++) begin
        case ($urandom_range(39))
          0: send_op(cbfd_pkg::ACT_REWIND);
          1: send_op(ACT_UNKNOWN);
          default: ;
        endcase
        send_op(cbfd_pkg::ACT_FETCH);
      end
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_op(cbfd_pkg::ACT_FETCH);
    send_op(cbfd_pkg::ACT_REWIND);
    send_op(cbfd_pkg::ACT_FETCH);
    send_curve(-24'sd8388608, 24'sd8388607, 24'sd8388607, -24'sd8388608,
               -24'sd8388608, -24'sd8388608, 24'sd8388607, 24'sd8388607);
    repeat (4) send_op(cbfd_pkg::ACT_FETCH);
    send_curve('0, '0, '0, '0, '0, '0, '0, '0);
    repeat (3) send_op(cbfd_pkg::ACT_FETCH);
    send_op(ACT_UNKNOWN);
    send_op(cbfd_pkg::ACT_REWIND);
    repeat (7) send_op(cbfd_pkg::ACT_FETCH);
    send_curve(24'sd256, -24'sd512, 24'sd3000, 24'sd4000, -24'sd2000, 24'sd1000,
               24'sd5000, -24'sd700);
    repeat (4) send_op(cbfd_pkg::ACT_FETCH);
  endtask

  task automatic test_full_rate();
    write_scale(16'd256);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_walks(300, 6000);
  endtask

  task automatic test_sender_gaps();
    write_scale(16'd1);
    send_idle_pct = 66;
    recv_stall_pct = 0;
    run_walks(250, 6000);
  endtask

  task automatic test_receiver_stalls();
    write_scale(16'hFFFF);
    send_idle_pct = 0;
    recv_stall_pct = 66;
    run_walks(300, 20);
  endtask

  task automatic test_both_idle();
    write_scale(16'd0);
    send_idle_pct = 31;
    recv_stall_pct = 31;
    run_walks(200, 6000);
    write_scale(16'($urandom_range(900, 100)));
    run_walks(150, 3000);
  endtask

  task automatic test_backpressure();
    write_scale(16'd512);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (600) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    send_curve('0, '0, 24'sd4000, 24'sd4000, 24'sd8000, -24'sd4000, 24'sd12000, '0);
    repeat (12) send_op(cbfd_pkg::ACT_FETCH);
    run_walks(100, 4000);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = cbfd_pkg::ACT_FETCH;
    {in_ch.p0_x, in_ch.p0_y, in_ch.p1_x, in_ch.p1_y} = '0;
    {in_ch.p2_x, in_ch.p2_y, in_ch.p3_x, in_ch.p3_y} = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.approx_scale = '0;
    hold_off = 1'b0;
    errors = 0;
    cycles = 0;
    sent = 0;
    flattener_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_rate();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
